@@ src/vtksm_pkg.sv @@
// shared types, byte codes and the key pattern table of the vt102 key sequence matcher
package vtksm_pkg;

   localparam int SEQ_DEPTH_DEFAULT = 8;
   localparam int NUM_PATTERNS = 26;
   localparam int PAT_MAX = 4;
   localparam int INDEX_W = 5;

   localparam logic [7:0] BYTE_ESC = 8'h1B;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
   localparam logic [7:0] ESC_FINAL_LO = 8'h30;
   localparam logic [7:0] ESC_FINAL_HI = 8'h7F;
   localparam logic [7:0] CSI_FINAL_LO = 8'h40;
   localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

   typedef enum logic [2:0] {
      PHASE_PLAIN = 3'b001,
      PHASE_ESC   = 3'b010,
      PHASE_CSI   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      OUTCOME_PENDING  = 2'd0,
      OUTCOME_NO_MATCH = 2'd1,
      OUTCOME_MATCH    = 2'd2
   } outcome_type;

   typedef logic [7:0] pat_bytes_type [PAT_MAX];

   localparam logic [2:0] PAT_LEN [NUM_PATTERNS] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
      3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2
   };

   // unused tail bytes are never compared
   localparam pat_bytes_type PAT_BYTES [NUM_PATTERNS] = '{
      '{8'h1B, 8'h5B, 8'h41, 8'h00},
      '{8'h1B, 8'h5B, 8'h42, 8'h00},
      '{8'h1B, 8'h5B, 8'h43, 8'h00},
      '{8'h1B, 8'h5B, 8'h44, 8'h00},
      '{8'h7F, 8'h00, 8'h00, 8'h00},
      '{8'h0A, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h00, 8'h00, 8'h00},
      '{8'h05, 8'h00, 8'h00, 8'h00},
      '{8'h0B, 8'h00, 8'h00, 8'h00},
      '{8'h19, 8'h00, 8'h00, 8'h00},
      '{8'h03, 8'h00, 8'h00, 8'h00},
      '{8'h06, 8'h00, 8'h00, 8'h00},
      '{8'h02, 8'h00, 8'h00, 8'h00},
      '{8'h1B, 8'h5B, 8'h33, 8'h7E},
      '{8'h09, 8'h00, 8'h00, 8'h00},
      '{8'h04, 8'h00, 8'h00, 8'h00},
      '{8'h0C, 8'h00, 8'h00, 8'h00},
      '{8'h0D, 8'h00, 8'h00, 8'h00},
      '{8'h1B, 8'h7F, 8'h00, 8'h00},
      '{8'h1B, 8'h62, 8'h00, 8'h00},
      '{8'h1B, 8'h66, 8'h00, 8'h00},
      '{8'h3F, 8'h00, 8'h00, 8'h00},
      '{8'h17, 8'h00, 8'h00, 8'h00},
      '{8'h10, 8'h00, 8'h00, 8'h00},
      '{8'h0E, 8'h00, 8'h00, 8'h00},
      '{8'h1B, 8'h64, 8'h00, 8'h00}
   };

endpackage

@@ src/vt102_key_sequence_matcher.sv @@
// Key sequence matcher: takes one terminal byte per request and returns one result per byte.
// The result is pending while an ESC or ESC-[ sequence is still open. When a sequence closes,
// the result is either the index of the matching key pattern or no-match. The block accepts
// one byte every clock cycle as long as results are taken. Each request passes an input
// register and then a result register. The phase, the length count and the first four
// sequence bytes are updated in the same cycle that the result register is loaded, and all
// 26 pattern compares run in parallel in that cycle. While the result register is stalled,
// one more request is still taken into the input register. SEQ_DEPTH sets how many bytes a
// sequence may hold before the parser drops it and starts over in the plain phase.
module vt102_key_sequence_matcher
   import vtksm_pkg::*;
#(
   parameter int SEQ_DEPTH = SEQ_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_outcome,
   output logic [INDEX_W-1:0] rsp_command_index
);

   localparam int LEN_W = $clog2(SEQ_DEPTH + 1);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   outcome_type        outcome_ff, outcome_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [7:0]         bytes_ff [PAT_MAX];
   logic [7:0]         bytes_in [PAT_MAX];

   logic               out_block;
   logic               process;
   logic               req_take;
   phase_type          phase_eff;
   logic [LEN_W-1:0]   pos;
   logic [LEN_W-1:0]   n;
   logic [7:0]         cand [PAT_MAX];
   logic               close_seq;
   logic               found;
   logic [INDEX_W-1:0] found_index;
   logic               pat_hit;

   assign out_block = rsp_valid_ff & rsp_stall;
   assign process = in_valid_ff & ~out_block;
   assign req_stall = in_valid_ff & out_block;
   assign req_take = req_valid & ~req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_command_index = index_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
   end

   // a full buffer drops the sequence before the byte is placed
   always_comb begin
      if (len_ff == LEN_W'(SEQ_DEPTH)) begin
         phase_eff = PHASE_PLAIN;
         pos = '0;
      end else begin
         phase_eff = phase_ff;
         pos = len_ff;
      end
      n = pos + LEN_W'(1);
   end

   always_comb begin
      for (int k = 0; k < PAT_MAX; k++) begin
         cand[k] = (pos == LEN_W'(k)) ? in_byte_ff : bytes_ff[k];
         bytes_in[k] = process ? cand[k] : bytes_ff[k];
      end
   end

   // lowest matching index wins
   always_comb begin
      found = 1'b0;
      found_index = '0;
      pat_hit = 1'b0;
      for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
         pat_hit = (n == LEN_W'(PAT_LEN[i]));
         for (int k = 0; k < PAT_MAX; k++) begin
            if ((LEN_W'(k) < n) && (cand[k] != PAT_BYTES[i][k])) begin
               pat_hit = 1'b0;
            end
         end
         if (pat_hit) begin
            found = 1'b1;
            found_index = INDEX_W'(i);
         end
      end
   end

   always_comb begin
      close_seq = 1'b0;
      phase_in = phase_eff;
      len_in = n;
      unique case (phase_eff)
         PHASE_PLAIN: begin
            if (in_byte_ff == BYTE_ESC) begin
               phase_in = PHASE_ESC;
            end else begin
               close_seq = 1'b1;
            end
         end
         PHASE_ESC: begin
            if (in_byte_ff == BYTE_LBRACKET) begin
               phase_in = PHASE_CSI;
            end else if (in_byte_ff >= ESC_FINAL_LO && in_byte_ff <= ESC_FINAL_HI) begin
               close_seq = 1'b1;
            end
         end
         PHASE_CSI: begin
            if (in_byte_ff >= CSI_FINAL_LO && in_byte_ff <= CSI_FINAL_HI) begin
               close_seq = 1'b1;
            end
         end
         default: begin
            len_in = '0;
         end
      endcase
      if (close_seq) begin
         phase_in = PHASE_PLAIN;
         len_in = '0;
      end
      if (!process) begin
         phase_in = phase_ff;
         len_in = len_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      outcome_in = outcome_ff;
      index_in = index_ff;
      if (process) begin
         rsp_valid_in = 1'b1;
         if (!close_seq) begin
            outcome_in = OUTCOME_PENDING;
            index_in = '0;
         end else if (found) begin
            outcome_in = OUTCOME_MATCH;
            index_in = found_index;
         end else begin
            outcome_in = OUTCOME_NO_MATCH;
            index_in = '0;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PHASE_PLAIN;
         len_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      outcome_ff <= outcome_in;
      index_ff <= index_in;
      for (int k = 0; k < PAT_MAX; k++) begin
         bytes_ff[k] <= bytes_in[k];
      end
   end

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(SEQ_DEPTH))
      else $error("sequence length beyond buffer depth");

   a_plain_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_PLAIN) == (len_ff == '0))
      else $error("phase and sequence length disagree");

   a_match_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && outcome_ff == OUTCOME_MATCH |-> index_ff < INDEX_W'(NUM_PATTERNS))
      else $error("matched index out of pattern range");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && outcome_ff != OUTCOME_MATCH |-> index_ff == '0)
      else $error("index set without a match");

   a_process_result: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed request produced no result");
`endif

endmodule
